FILE: hw/rtl/dsv_pkg.sv
// Package: shared constants and types for the DSA signature verifier.
package dsv_pkg;

    localparam int unsigned ModWidth = 32;
    localparam int unsigned DigestWidth = 64;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [31:0] ResetPrime = 32'd23;
    localparam logic [31:0] ResetOrder = 32'd11;
    localparam logic [31:0] ResetGen = 32'd2;

    typedef enum logic [1:0] {
        CFG_PRIME = 2'd0,
        CFG_ORDER = 2'd1,
        CFG_GEN   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_VALID  = 2'd0,
        ST_RANGE  = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    // which exponentiation the shared loop is running
    typedef enum logic [1:0] {
        PW_INV = 2'd0,
        PW_GEN = 2'd1,
        PW_KEY = 2'd2
    } t_pow_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HRED,
        S_LOOP_CHK,
        S_LOOP_MUL,
        S_LOOP_SQR,
        S_U1,
        S_U2,
        S_GRED,
        S_YRED,
        S_VMUL,
        S_VRED,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/dsv_if.sv
// Interfaces: request and result channels.
interface dsv_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] public_key;
    logic [63:0] message_digest;
    logic [31:0] sig_r;
    logic [31:0] sig_s;
    modport source (output valid, public_key, message_digest, sig_r, sig_s, input ready);
    modport sink (input valid, public_key, message_digest, sig_r, sig_s, output ready);
endinterface

interface dsv_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] status;
    modport source (output valid, accepted, status, input ready);
    modport sink (input valid, accepted, status, output ready);
endinterface

FILE: hw/rtl/dsv_modred.sv
// Shared unit: bit-serial reduction of a 64-bit value by a variable modulus.
module dsv_modred #(
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_value,
    input  logic [MOD_WIDTH-1:0] i_mod,
    output logic                 o_done,
    output logic [MOD_WIDTH-1:0] o_result
);
    import dsv_pkg::*;

    logic [63:0]        r_val;
    logic [MOD_WIDTH:0] r_rem;
    logic [6:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MOD_WIDTH+1:0] w_sh;
    logic [MOD_WIDTH+1:0] w_diff;

    assign w_sh = {r_rem, r_val[63]};
    assign w_diff = w_sh - {2'b00, i_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_val  <= i_value;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[62:0], 1'b0};
                if (w_sh >= {2'b00, i_mod}) begin
                    r_rem <= w_diff[MOD_WIDTH:0];
                end else begin
                    r_rem <= w_sh[MOD_WIDTH:0];
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_result = r_rem[MOD_WIDTH-1:0];

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, i_mod})) else $error("remainder not reduced");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !r_busy || $past(i_start)) else $error("spurious start");
`endif
endmodule

FILE: hw/rtl/dsa_signature_verify_top.sv
// Top level: DSA signature verifier with one shared modular reduction unit.
//
// Usage: write p, q, g through the configuration port (index 0, 1, 2) while
// idle. A request transaction carries public_key, message_digest, sig_r and
// sig_s; one result transaction per request returns accepted and status.
// Every modular product is formed by one multiply into an operand register
// and then reduced by the bit-serial reduction unit, which loads the
// operand, runs 64 shift-subtract steps and then hands back the remainder.
// Exponent loop: one check per exponent bit, a multiply step when the
// bit is set and a square step unless it is the last bit.
// A range reject or a zero modulus goes from idle straight to the done
// state without using the reduction unit. A full verify is paced by the
// reduction unit; small exponents finish earlier.
// Throughput: one request at a time; request ready is high only in idle.
// The result waits in an output register until taken; the next request may
// be accepted and worked on meanwhile, and its finish waits for that
// register if the receiver is still stalled.
// Reset (synchronous, active low) restores p=23, q=11, g=2 and aborts any
// request in progress.
module dsa_signature_verify_top #(
    parameter int unsigned MOD_WIDTH = dsv_pkg::ModWidth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dsv_req_if.sink                        req,
    dsv_rsp_if.source                      rsp,
    input  logic                           i_cfg_we,
    input  logic [dsv_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);
    import dsv_pkg::*;

    localparam int unsigned W = MOD_WIDTH;
    localparam logic [W-1:0] One = {{(W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] Two = {{(W-2){1'b0}}, 2'b10};

    t_state   r_state, n_state;
    t_pow_sel r_sel;

    logic [W-1:0]  r_p, r_q, r_g;
    logic [W-1:0]  r_y, r_r, r_s;
    logic [W-1:0]  r_hq, r_w, r_u1, r_u2, r_ga;
    logic [W-1:0]  r_acc, r_sq, r_e;
    logic [63:0]   r_mop;
    logic [W-1:0]  r_mmod;
    logic          r_go;     // start pulse for the reduction unit
    t_status       r_fstat;  // verdict waiting for the output register
    logic          r_rvalid;
    logic          r_racc;
    t_status       r_rstat;

    logic          w_done;
    logic [W-1:0]  w_res;
    logic          w_acc_req;
    logic          w_range_bad;
    logic          w_issue;
    logic          w_e_last;
    logic          w_slot_free;
    logic [W-1:0]  w_ma, w_mb;
    logic [2*W-1:0] w_prod;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= ResetPrime[W-1:0];
            r_q <= ResetOrder[W-1:0];
            r_g <= ResetGen[W-1:0];
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PRIME: r_p <= i_cfg_data[W-1:0];
                CFG_ORDER: r_q <= i_cfg_data[W-1:0];
                CFG_GEN:   r_g <= i_cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    dsv_modred #(.MOD_WIDTH(W)) u_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_go),
        .i_value(r_mop), .i_mod(r_mmod), .o_done(w_done), .o_result(w_res)
    );

    assign req.ready = (r_state == S_IDLE);
    assign rsp.valid = r_rvalid;
    assign rsp.accepted = r_racc;
    assign rsp.status = r_rstat;

    assign w_acc_req = req.valid && req.ready;
    assign w_range_bad = (req.sig_r[W-1:0] == '0) || (req.sig_r[W-1:0] >= r_q)
                       || (req.sig_s[W-1:0] == '0) || (req.sig_s[W-1:0] >= r_q);
    assign w_e_last = (r_e[W-1:1] == '0);
    assign w_slot_free = !r_rvalid || rsp.ready;

    // every entry into a waiting state starts one reduction
    assign w_issue = (n_state != r_state) && (n_state != S_IDLE)
                   && (n_state != S_LOOP_CHK) && (n_state != S_DONE);

    // shared multiplier operands
    always_comb begin
        w_ma = r_acc;
        w_mb = r_sq;
        case (r_state)
            S_LOOP_CHK: begin
                if (r_e == '0) begin
                    w_ma = (r_sel == PW_INV) ? r_hq : r_ga;
                    w_mb = r_acc;
                end else if (!r_e[0]) begin
                    w_ma = r_sq;
                end
            end
            S_LOOP_MUL: w_ma = r_sq;
            S_U1: begin
                w_ma = r_r;
                w_mb = r_w;
            end
            default: ;
        endcase
    end

    assign w_prod = {{W{1'b0}}, w_ma} * {{W{1'b0}}, w_mb};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_req) begin
                    n_state = (w_range_bad || r_p == '0) ? S_DONE : S_HRED;
                end
            end
            S_HRED:     if (w_done) n_state = S_LOOP_CHK;
            S_LOOP_CHK: begin
                if (r_e != '0) begin
                    n_state = r_e[0] ? S_LOOP_MUL : S_LOOP_SQR;
                end else begin
                    case (r_sel)
                        PW_INV:  n_state = S_U1;
                        PW_GEN:  n_state = S_YRED;
                        default: n_state = S_VMUL;
                    endcase
                end
            end
            S_LOOP_MUL: if (w_done) n_state = w_e_last ? S_LOOP_CHK : S_LOOP_SQR;
            S_LOOP_SQR: if (w_done) n_state = S_LOOP_CHK;
            S_U1:       if (w_done) n_state = S_U2;
            S_U2:       if (w_done) n_state = S_GRED;
            S_GRED:     if (w_done) n_state = S_LOOP_CHK;
            S_YRED:     if (w_done) n_state = S_LOOP_CHK;
            S_VMUL:     if (w_done) n_state = S_VRED;
            S_VRED:     if (w_done) n_state = S_DONE;
            S_DONE:     if (w_slot_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_issue;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= PW_INV;
            r_fstat <= ST_VALID;
        end else begin
            case (r_state)
                S_IDLE: if (w_acc_req) begin
                    r_y <= req.public_key[W-1:0];
                    r_r <= req.sig_r[W-1:0];
                    r_s <= req.sig_s[W-1:0];
                    r_mop  <= req.message_digest;
                    r_mmod <= r_q;
                    // zero modulus: v cannot be formed
                    r_fstat <= w_range_bad ? ST_RANGE : ST_MISMATCH;
                end
                S_HRED: if (w_done) begin
                    // s is below q already; set up w = s^(q-2) mod q
                    r_hq  <= w_res;
                    r_sq  <= r_s;
                    r_acc <= One;
                    r_e   <= r_q - Two;
                    r_sel <= PW_INV;
                end
                S_LOOP_CHK: begin
                    if (r_e != '0) begin
                        r_mop <= 64'(w_prod);
                    end else begin
                        case (r_sel)
                            PW_INV: begin
                                r_w   <= r_acc;
                                r_mop <= 64'(w_prod);
                            end
                            PW_GEN: begin
                                r_ga  <= r_acc;
                                r_mop <= 64'(r_y);
                            end
                            default: r_mop <= 64'(w_prod);
                        endcase
                    end
                end
                S_LOOP_MUL: if (w_done) begin
                    r_acc <= w_res;
                    // last exponent bit: the final square is not needed
                    if (w_e_last) r_e <= '0;
                    else r_mop <= 64'(w_prod);
                end
                S_LOOP_SQR: if (w_done) begin
                    r_sq <= w_res;
                    r_e  <= r_e >> 1;
                end
                S_U1: if (w_done) begin
                    r_u1  <= w_res;
                    r_mop <= 64'(w_prod);
                end
                S_U2: if (w_done) begin
                    r_u2   <= w_res;
                    r_mop  <= 64'(r_g);
                    r_mmod <= r_p;
                end
                S_GRED: if (w_done) begin
                    r_sq  <= w_res;
                    r_acc <= One;
                    r_e   <= r_u1;
                    r_sel <= PW_GEN;
                end
                S_YRED: if (w_done) begin
                    r_sq  <= w_res;
                    r_acc <= One;
                    r_e   <= r_u2;
                    r_sel <= PW_KEY;
                end
                S_VMUL: if (w_done) begin
                    r_mop  <= 64'(w_res);
                    r_mmod <= r_q;
                end
                S_VRED: if (w_done) begin
                    r_fstat <= (w_res == r_r) ? ST_VALID : ST_MISMATCH;
                end
                default: ;
            endcase
        end
    end

    // output register: loaded when free or being taken in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
            r_racc   <= 1'b0;
            r_rstat  <= ST_VALID;
        end else if (r_state == S_DONE && w_slot_free) begin
            r_rvalid <= 1'b1;
            r_racc   <= (r_fstat == ST_VALID);
            r_rstat  <= r_fstat;
        end else if (rsp.valid && rsp.ready) begin
            r_rvalid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !req.ready) else $error("ready while busy");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid |-> (r_racc == (r_rstat == ST_VALID))) else $error("status mismatch");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid && !rsp.ready |=> r_rvalid && $stable(r_racc) && $stable(r_rstat))
        else $error("result changed while stalled");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state != S_IDLE) && (r_state != S_LOOP_CHK) && (r_state != S_DONE))
        else $error("reduction done outside a wait state");
`endif
endmodule

FILE: tb/tb_dsa_signature_verify_top.sv
// Testbench for the DSA signature verifier: directed and random requests checked against a predictor.
module tb_dsa_signature_verify_top;
    import dsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A request stalls for at most one full verify at 32-bit q plus a
    // receiver stall; leave wide margin.
    localparam int unsigned WatchdogLimit = 60000;
    // Cycles allowed after the last result before config writes or the end.
    localparam int unsigned SettleCycles = 20;

    typedef struct {
        logic [31:0] pub_key;
        logic [63:0] digest;
        logic [31:0] r_val;
        logic [31:0] s_val;
    } t_sig_req;

    typedef struct {
        logic    accepted;
        t_status status;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxWidth-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    dsv_req_if req_ch ();
    dsv_rsp_if rsp_ch ();

    dsa_signature_verify_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the domain parameters, updated on every write.
    logic [31:0] dom_p;
    logic [31:0] dom_q;
    logic [31:0] dom_g;

    t_sig_req pending_reqs[$];
    t_verdict verdicts_due[$];

    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned req_gap = 0;
    int unsigned rsp_hold = 0;
    int unsigned sent_count = 0;   // transactions taken from the queue
    int unsigned done_count = 0;   // results received
    bit no_idle = 0;     // when set, both sides run back to back
    logic req_fire = 1'b0;
    logic rsp_fire = 1'b0;

    // Clock: 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Modular arithmetic for the predictor. Residues stay below 2^32,
    // so a product of two fits in 64 bits.
    // ---------------------------------------------------------------
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return ((a % m) * (b % m)) % m;
    endfunction

    // Right-to-left square-and-multiply; an exponent of zero gives 1, unreduced.
    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq = b % m;
        while (e != 0) begin
            if (e[0])
                acc = mulmod(acc, sq, m);
            e = e >> 1;
            sq = mulmod(sq, sq, m);
        end
        return acc;
    endfunction

    // Expected verdict under the current domain parameters.
    function automatic t_verdict predict_verdict(t_sig_req it);
        t_verdict vd;
        logic [63:0] p, q, g, w, u1, u2, v;
        p = {32'd0, dom_p};
        q = {32'd0, dom_q};
        g = {32'd0, dom_g};
        vd.accepted = 1'b0;
        // r and s must lie in 1..q-1; this also rejects everything when q < 2
        if (it.r_val == 0 || it.r_val >= q || it.s_val == 0 || it.s_val >= q) begin
            vd.status = ST_RANGE;
            return vd;
        end
        // zero modulus: v cannot be formed
        if (p == 0) begin
            vd.status = ST_MISMATCH;
            return vd;
        end
        w = powmod({32'd0, it.s_val}, q - 2, q);
        u1 = mulmod(it.digest % q, w, q);
        u2 = mulmod({32'd0, it.r_val}, w, q);
        v = mulmod(powmod(g, u1, p), powmod({32'd0, it.pub_key}, u2, p), p) % q;
        if (v == {32'd0, it.r_val}) begin
            vd.accepted = 1'b1;
            vd.status = ST_VALID;
        end else begin
            vd.status = ST_MISMATCH;
        end
        return vd;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random value in 1..q-1 (q >= 2).
    function automatic logic [31:0] in_range(logic [31:0] q);
        return 32'd1 + ($urandom() % (q - 32'd1));
    endfunction

    // Proper signature: needs prime q, p > 0 and g of order q.
    function automatic t_sig_req make_signed(logic [63:0] digest);
        t_sig_req it;
        logic [63:0] p, q, x, k, r, s;
        p = {32'd0, dom_p};
        q = {32'd0, dom_q};
        it.digest = digest;
        it.pub_key = $urandom();
        it.r_val = 32'd1;
        it.s_val = 32'd1;
        for (int tries = 0; tries < 64; tries++) begin
            x = 64'(in_range(dom_q));
            k = 64'(in_range(dom_q));
            r = powmod({32'd0, dom_g}, k, p) % p % q;
            s = mulmod(powmod(k, q - 2, q), (digest % q + mulmod(x, r, q)) % q, q);
            if (r != 0 && s != 0) begin
                it.pub_key = 32'(powmod({32'd0, dom_g}, x, p) % p);
                it.r_val = r[31:0];
                it.s_val = s[31:0];
                break;
            end
        end
        return it;
    endfunction

    // Mix of good signatures, damaged ones, in-range noise and raw noise.
    function automatic t_sig_req random_request(bit can_sign);
        t_sig_req it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (can_sign && pick < 55) begin
            it = make_signed(rand64());
        end else if (can_sign && pick < 70) begin
            it = make_signed(rand64());
            case ($urandom_range(0, 3))
                0: it.r_val = (it.r_val % (dom_q - 1)) + 1;
                1: it.digest = it.digest + 64'd1;
                2: it.pub_key = it.pub_key ^ 32'd1;
                default: it.s_val = (it.s_val % (dom_q - 1)) + 1;
            endcase
        end else if (dom_q >= 2 && pick < 85) begin
            it.pub_key = $urandom();
            it.digest = rand64();
            it.r_val = in_range(dom_q);
            it.s_val = in_range(dom_q);
        end else begin
            it.pub_key = $urandom();
            it.digest = rand64();
            it.r_val = $urandom();
            it.s_val = $urandom();
        end
        return it;
    endfunction

    function automatic t_sig_req raw_request(logic [31:0] y, logic [63:0] h,
                                            logic [31:0] r, logic [31:0] s);
        t_sig_req it;
        it.pub_key = y;
        it.digest = h;
        it.r_val = r;
        it.s_val = s;
        return it;
    endfunction

    function automatic int unsigned draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // ---------------------------------------------------------------
    // Sequencing tasks
    // ---------------------------------------------------------------
    // Block until every queued transaction has its result back.
    task automatic drain_all();
        while (pending_reqs.size() != 0 || sent_count != done_count)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PRIME: dom_p = data;
            CFG_ORDER: dom_q = data;
            default:   dom_g = data;
        endcase
    endtask

    task automatic set_domain(logic [31:0] p, logic [31:0] q, logic [31:0] g);
        drain_all();
        cfg_write(CFG_PRIME, p);
        cfg_write(CFG_ORDER, q);
        cfg_write(CFG_GEN, g);
    endtask

    // Random requests; optionally the sender holds off halfway until all
    // outstanding results are back.
    task automatic random_burst(int unsigned count, bit can_sign, bit hold_mid);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int unsigned n = 0; n < count; n++) begin
            if (hold_mid && n == count / 2) begin
                while (pending_reqs.size() != 0 || sent_count != done_count)
                    @(negedge i_clk);
            end
            pending_reqs.push_back(random_request(can_sign));
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [31:0] gen;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PRIME;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.public_key = '0;
        req_ch.message_digest = '0;
        req_ch.sig_r = '0;
        req_ch.sig_s = '0;
        rsp_ch.ready = 1'b0;
        dom_p = ResetPrime;
        dom_q = ResetOrder;
        dom_g = ResetGen;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset domain (p=23, q=11, g=2), field extremes, range edges.
        pending_reqs.push_back(make_signed(64'd0));
        pending_reqs.push_back(make_signed(64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(make_signed(64'h8000_0000_0000_0005));
        pending_reqs.push_back(raw_request(32'd3, 64'd7, 32'd0, 32'd5));
        pending_reqs.push_back(raw_request(32'd3, 64'd7, 32'd5, 32'd0));
        pending_reqs.push_back(raw_request(32'd3, 64'd7, 32'd11, 32'd5));
        pending_reqs.push_back(raw_request(32'd3, 64'd7, 32'd5, 32'd11));
        pending_reqs.push_back(raw_request(32'd3, 64'd7, 32'd10, 32'd10));
        pending_reqs.push_back(raw_request(32'd3, 64'd7, 32'd1, 32'd1));
        pending_reqs.push_back(raw_request('1, '1, '1, '1));
        pending_reqs.push_back(raw_request('0, '0, '0, '0));
        // key outside the group, used as given
        pending_reqs.push_back(raw_request('1, 64'd9, 32'd4, 32'd7));
        random_burst(30, 1'b1, 1'b1);

        // Small textbook domain: 606 = 6 * 101, g = 2^6 mod 607.
        set_domain(32'd607, 32'd101, 32'd64);
        random_burst(35, 1'b1, 1'b0);

        // Mersenne prime 2^31-1 with q = 331 dividing p-1.
        gen = 32'(powmod(64'd3, (64'd2147483647 - 1) / 331, 64'd2147483647));
        set_domain(32'd2147483647, 32'd331, gen);
        random_burst(35, 1'b1, 1'b1);

        // Order of two: w is always 1.
        set_domain(32'd3, 32'd2, 32'd2);
        pending_reqs.push_back(raw_request(32'd2, 64'd0, 32'd1, 32'd1));
        pending_reqs.push_back(raw_request(32'd1, 64'd1, 32'd1, 32'd1));
        random_burst(4, 1'b1, 1'b0);

        // Order below two: every request is a range reject.
        set_domain(32'd23, 32'd0, 32'd2);
        pending_reqs.push_back(raw_request(32'd5, 64'd3, 32'd0, 32'd0));
        random_burst(3, 1'b0, 1'b0);
        drain_all();
        cfg_write(CFG_ORDER, 32'd1);
        pending_reqs.push_back(raw_request(32'd5, 64'd3, 32'd1, 32'd1));
        random_burst(2, 1'b0, 1'b0);

        // Zero modulus, then modulus of one.
        set_domain(32'd0, 32'd11, 32'd2);
        pending_reqs.push_back(raw_request(32'd5, 64'd3, 32'd3, 32'd4));
        random_burst(3, 1'b0, 1'b0);
        set_domain(32'd1, 32'd11, 32'd2);
        pending_reqs.push_back(raw_request(32'd5, 64'd3, 32'd3, 32'd4));
        random_burst(3, 1'b0, 1'b0);

        // Zero generator.
        set_domain(32'd23, 32'd11, 32'd0);
        random_burst(4, 1'b0, 1'b0);

        // Widest values: full 32-bit exponents make these slow, keep it short.
        set_domain(32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'hFFFF_FFFF);
        pending_reqs.push_back(raw_request('1, '1, 32'hFFFF_FFFA, 32'hFFFF_FFFA));
        random_burst(2, 1'b0, 1'b0);
        set_domain(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001);
        pending_reqs.push_back(raw_request('1, '1, 32'hFFFF_FFFE, 32'hFFFF_FFFE));

        drain_all();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request driver: one transaction from the queue at a time, random
    // gaps between transactions. Changes land on the falling edge.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_sig_req it;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_fire) begin
            // still waiting for ready; hold the transaction
        end else if (req_gap != 0) begin
            req_ch.valid <= 1'b0;
            req_gap <= req_gap - 1;
        end else if (pending_reqs.size() != 0) begin
            it = pending_reqs.pop_front();
            sent_count++;
            req_ch.public_key <= it.pub_key;
            req_ch.message_digest <= it.digest;
            req_ch.sig_r <= it.r_val;
            req_ch.sig_s <= it.s_val;
            req_ch.valid <= 1'b1;
            req_gap <= draw_wait();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Result side back-pressure: a fresh stall drawn after every transaction.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_fire)
                rsp_hold = draw_wait();
            else if (rsp_hold != 0)
                rsp_hold = rsp_hold - 1;
            rsp_ch.ready <= (rsp_hold == 0);
        end
    end

    task automatic report_mismatch(string what, logic [1:0] got, logic [1:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Monitor: predict on accepted requests, check accepted results,
    // and watch for a hang.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict want;
        t_sig_req seen;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            rsp_fire <= 1'b0;
        end else begin
            req_fire <= req_ch.valid && req_ch.ready;
            rsp_fire <= rsp_ch.valid && rsp_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                seen.pub_key = req_ch.public_key;
                seen.digest = req_ch.message_digest;
                seen.r_val = req_ch.sig_r;
                seen.s_val = req_ch.sig_s;
                verdicts_due.push_back(predict_verdict(seen));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                done_count++;
                if (verdicts_due.size() == 0) begin
                    report_mismatch("unexpected result", {1'b0, rsp_ch.accepted}, 2'd0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (rsp_ch.accepted !== want.accepted)
                        report_mismatch("accepted", {1'b0, rsp_ch.accepted},
                                        {1'b0, want.accepted});
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                end
            end
            // watchdog: cycles with no transaction on either channel
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WatchdogLimit) begin
                $display("timeout: no transaction for %0d cycles", stall_cycles);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule

FILE: filelist.f
hw/rtl/dsv_pkg.sv
hw/rtl/dsv_if.sv
hw/rtl/dsv_modred.sv
hw/rtl/dsa_signature_verify_top.sv
tb/tb_dsa_signature_verify_top.sv
